// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/lpf_pkg.sv =====
// ---------------------------------------------------------------------------
// lpf_pkg
// shared constants, microcode types and status flags of the palindrome finder
// ---------------------------------------------------------------------------
package lpf_pkg;

   localparam int MAX_LEN   = 256;
   localparam int CNT_W     = $clog2(MAX_LEN + 1);
   localparam int POS_W     = CNT_W + 1;
   localparam int RAD_W     = CNT_W;
   localparam int ADDR_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int RAD_DEPTH = 2 * MAX_LEN + 1;

   localparam int CHAR_W     = 8;
   localparam int START_W    = 8;
   localparam int LEN_W      = 9;
   localparam int CENTER_W   = 9;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_FIELD_W = START_W + LEN_W + CENTER_W;
   localparam int RSP_DATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   typedef enum logic [3:0] {
      STEP_IDLE,
      STEP_INIT,
      STEP_POS,
      STEP_MIRROR,
      STEP_CHECK,
      STEP_EXP_READ,
      STEP_EXP_CMP,
      STEP_WRITE,
      STEP_NEXT,
      STEP_DONE
   } step_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_START,
      COND_SCAN_END,
      COND_NO_EXPAND,
      COND_OUT_OF_BOUNDS,
      COND_MATCH,
      COND_MORE,
      COND_OUT_FREE
   } cond_type;

   typedef struct packed {
      logic     accept;
      logic     init;
      logic     set_r;
      logic     clip_r;
      logic     text_rd;
      logic     grow_r;
      logic     rad_wr;
      logic     advance;
      logic     emit;
      cond_type cond;
      step_type target;
      logic     hold;
   } ctrl_type;

   typedef struct packed {
      logic start;
      logic scan_end;
      logic no_expand;
      logic out_of_bounds;
      logic match;
      logic more;
      logic out_free;
   } flags_type;

endpackage

// ===== hw/rtl/lpf_sequencer.sv =====
// ---------------------------------------------------------------------------
// lpf_sequencer
// step counter and control store driving the scan datapath
// ---------------------------------------------------------------------------
module lpf_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  lpf_pkg::flags_type  flags,
   output lpf_pkg::ctrl_type   ctrl
);
   import lpf_pkg::*;

   step_type upc_ff;
   step_type upc_in;
   ctrl_type word;
   logic     cond_true;

   function automatic ctrl_type rom(input step_type step);
      ctrl_type w;
      w        = '0;
      w.cond   = COND_NONE;
      w.target = STEP_IDLE;
      unique case (step)
         STEP_IDLE: begin
            w.accept = 1'b1;
            w.cond   = COND_START;
            w.target = STEP_INIT;
            w.hold   = 1'b1;
         end
         STEP_INIT: begin
            w.init   = 1'b1;
         end
         STEP_POS: begin
            w.set_r  = 1'b1;
            w.cond   = COND_SCAN_END;
            w.target = STEP_DONE;
         end
         STEP_MIRROR: begin
            w.clip_r = 1'b1;
         end
         STEP_CHECK: begin
            w.cond   = COND_NO_EXPAND;
            w.target = STEP_WRITE;
         end
         STEP_EXP_READ: begin
            w.text_rd = 1'b1;
            w.cond    = COND_OUT_OF_BOUNDS;
            w.target  = STEP_WRITE;
         end
         STEP_EXP_CMP: begin
            w.grow_r = 1'b1;
            w.cond   = COND_MATCH;
            w.target = STEP_EXP_READ;
         end
         STEP_WRITE: begin
            w.rad_wr = 1'b1;
         end
         STEP_NEXT: begin
            w.advance = 1'b1;
            w.cond    = COND_MORE;
            w.target  = STEP_POS;
         end
         STEP_DONE: begin
            w.emit   = 1'b1;
            w.cond   = COND_OUT_FREE;
            w.target = STEP_IDLE;
            w.hold   = 1'b1;
         end
         default: begin
            w.target = STEP_IDLE;
            w.cond   = COND_START;
         end
      endcase
      return w;
   endfunction

   // control word output
   always_comb begin
      word = rom(upc_ff);
      ctrl = word;
   end

   // next step
   always_comb begin
      unique case (word.cond)
         COND_NONE:          cond_true = 1'b0;
         COND_START:         cond_true = flags.start;
         COND_SCAN_END:      cond_true = flags.scan_end;
         COND_NO_EXPAND:     cond_true = flags.no_expand;
         COND_OUT_OF_BOUNDS: cond_true = flags.out_of_bounds;
         COND_MATCH:         cond_true = flags.match;
         COND_MORE:          cond_true = flags.more;
         COND_OUT_FREE:      cond_true = flags.out_free;
         default:            cond_true = 1'b0;
      endcase
      priority if (cond_true) begin
         upc_in = word.target;
      end else if (word.hold) begin
         upc_in = upc_ff;
      end else begin
         upc_in = step_type'(upc_ff + 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= STEP_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// ===== hw/rtl/lpf_datapath.sv =====
// ---------------------------------------------------------------------------
// lpf_datapath
// text buffer, radius memory, scan registers and result register
// ---------------------------------------------------------------------------
module lpf_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  lpf_pkg::ctrl_type                 ctrl,
   output lpf_pkg::flags_type                flags,
   input  logic                              req_tvalid,
   input  logic [lpf_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lpf_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import lpf_pkg::*;

   logic [CHAR_W-1:0] text_mem [MAX_LEN];
   logic [RAD_W-1:0]  rad_mem  [RAD_DEPTH];

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [POS_W-1:0]  p_ff, p_in;
   logic [RAD_W-1:0]  r_ff, r_in;
   logic [POS_W-1:0]  best_ff, best_in;
   logic [RAD_W-1:0]  best_len_ff, best_len_in;
   logic [POS_W-1:0]  rb_ff, rb_in;
   logic [CHAR_W-1:0] tq_lo_ff, tq_hi_ff;
   logic [RAD_W-1:0]  rad_q_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [START_W-1:0]    start_ff, start_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [CENTER_W-1:0]   center_ff, center_in;

   logic              load;
   logic              out_free;
   logic              emit_fire;
   logic [POS_W-1:0]  two_n;
   logic [POS_W:0]    p_x, r_x, rb_x, two_n_x;
   logic [POS_W:0]    mirror_x, lo_x, hi_x;
   logic [POS_W-1:0]  rad_raddr, rad_waddr, room, start_diff;
   logic [RAD_W-1:0]  rad_wdata;
   logic              in_bounds;

   assign load      = ctrl.accept && req_tvalid && (count_ff < CNT_W'(MAX_LEN));
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign emit_fire = ctrl.emit && out_free;

   assign two_n    = {count_ff, 1'b0};
   assign p_x      = {1'b0, p_ff};
   assign r_x      = {2'b00, r_ff};
   assign rb_x     = {1'b0, rb_ff};
   assign two_n_x  = {1'b0, two_n};
   assign mirror_x = {best_ff, 1'b0} - p_x;
   assign lo_x     = p_x - r_x - (POS_W+1)'(2);
   assign hi_x     = p_x + r_x;
   assign room     = rb_ff - p_ff;
   assign in_bounds = (p_x >= r_x + (POS_W+1)'(2)) &&
                      (p_x + r_x + (POS_W+1)'(2) <= two_n_x);

   assign rad_raddr  = (rb_ff > p_ff) ? mirror_x[POS_W-1:0] : '0;
   assign rad_waddr  = ctrl.init ? POS_W'(1) : p_ff;
   assign rad_wdata  = ctrl.init ? RAD_W'(1) : r_ff;
   assign start_diff = best_ff - {1'b0, best_len_ff};

   always_comb begin
      flags.start         = req_tvalid && req_tlast;
      flags.scan_end      = p_ff > two_n;
      flags.no_expand     = !((rb_ff < p_ff) || (hi_x == rb_x));
      flags.out_of_bounds = !in_bounds;
      flags.match         = tq_lo_ff == tq_hi_ff;
      flags.more          = !(rb_ff >= two_n);
      flags.out_free      = out_free;
   end

   // scan registers
   always_comb begin
      count_in    = count_ff;
      p_in        = p_ff;
      r_in        = r_ff;
      best_in     = best_ff;
      best_len_in = best_len_ff;
      rb_in       = rb_ff;
      if (load) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (ctrl.init) begin
         best_in     = POS_W'(1);
         best_len_in = RAD_W'(1);
         rb_in       = POS_W'(2);
         p_in        = POS_W'(2);
      end
      if (ctrl.set_r) begin
         r_in = {{(RAD_W-1){1'b0}}, p_ff[0]};
      end
      if (ctrl.clip_r && (rb_ff > p_ff)) begin
         r_in = ({1'b0, rad_q_ff} < room) ? rad_q_ff : room[RAD_W-1:0];
      end
      if (ctrl.grow_r && flags.match) begin
         r_in = r_ff + RAD_W'(2);
      end
      if (ctrl.rad_wr && (r_ff > best_len_ff)) begin
         best_in     = p_ff;
         best_len_in = r_ff;
         rb_in       = hi_x[POS_W-1:0];
      end
      if (ctrl.advance) begin
         p_in = p_ff + POS_W'(1);
      end
      if (emit_fire) begin
         count_in = '0;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      start_in     = start_ff;
      len_in       = len_ff;
      center_in    = center_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         start_in     = START_W'(start_diff[POS_W-1:1]);
         len_in       = LEN_W'(best_len_ff);
         center_in    = CENTER_W'(best_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         best_ff      <= POS_W'(1);
         best_len_ff  <= RAD_W'(1);
         rb_ff        <= POS_W'(2);
         p_ff         <= POS_W'(2);
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         best_ff      <= best_in;
         best_len_ff  <= best_len_in;
         rb_ff        <= rb_in;
         p_ff         <= p_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      r_ff      <= r_in;
      start_ff  <= start_in;
      len_ff    <= len_in;
      center_ff <= center_in;
   end

   // text buffer, one write and two read ports
   always_ff @(posedge clock) begin
      if (load) begin
         text_mem[count_ff[ADDR_W-1:0]] <= req_tdata[CHAR_W-1:0];
      end
      if (ctrl.text_rd) begin
         tq_lo_ff <= text_mem[lo_x[ADDR_W:1]];
         tq_hi_ff <= text_mem[hi_x[ADDR_W:1]];
      end
   end

   // radius memory, one write and one read port
   always_ff @(posedge clock) begin
      if (ctrl.init || ctrl.rad_wr) begin
         rad_mem[rad_waddr] <= rad_wdata;
      end
      if (ctrl.set_r) begin
         rad_q_ff <= rad_mem[rad_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({center_ff, len_ff, start_ff});

endmodule

// ===== hw/rtl/longest_palindrome_finder.sv =====
// ---------------------------------------------------------------------------
// longest_palindrome_finder
// longest palindromic substring search over a buffered byte string
// ---------------------------------------------------------------------------
// req channel: one byte per word in req_tdata, req_tlast marks the final
// byte. Bytes are buffered at one per cycle; bytes beyond the buffer size
// are dropped, a dropped final byte still starts the search.
// After the final byte the input stalls while a microcoded scan walks the
// 2n+1 interleaved positions: each position reads the mirrored radius, clips
// it to the border, compares a byte pair per expansion step until a mismatch
// or the string end, then writes its radius back. The steps follow from the
// single radius memory port and the registered text reads; the scan ends
// early once the border reaches the end of the string.
// rsp channel: one word per string with start, length and interleaved center
// of the longest palindrome, earliest center on a tie. The result sits in an
// output register; the next string loads while it waits. If the receiver
// stalls across a whole second search, that search holds until it is taken.
// Reset empties the buffer, drops any pending result and returns to loading.
// ---------------------------------------------------------------------------
module longest_palindrome_finder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lpf_pkg::REQ_DATA_W-1:0]    req_tdata,   // char_code
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lpf_pkg::RSP_DATA_W-1:0]    rsp_tdata    // start_pos, pal_length, center_index
);
   import lpf_pkg::*;

   ctrl_type  ctrl;
   flags_type flags;

   lpf_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   lpf_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .flags      (flags),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   assign req_tready = ctrl.accept;

endmodule

// ===== hw/rtl/lpf_checker.sv =====
// ---------------------------------------------------------------------------
// lpf_checker
// port-level checks of the palindrome finder, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lpf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              req_tlast,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [lpf_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import lpf_pkg::*;

   logic [LEN_W-1:0]    len;
   logic [CENTER_W-1:0] center;

   assign len    = rsp_tdata[START_W +: LEN_W];
   assign center = rsp_tdata[START_W + LEN_W +: CENTER_W];

   // stalled result word holds
   `ASSERT_NEXT(rsp_hold_a, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))

   // a final byte starts a search, so loading pauses
   `ASSERT_NEXT(last_stalls_a, clock, reset, req_tvalid && req_tready && req_tlast,
      !req_tready)

   // a result only appears at the end of a search
   `ASSERT_IMPLY(rsp_after_search_a, clock, reset, $rose(rsp_tvalid), $past(!req_tready))

   // length is nonzero and has the parity of its center
   `ASSERT_IMPLY(rsp_shape_a, clock, reset, rsp_tvalid,
      (len != '0) && (len[0] == center[0]))

endmodule

bind longest_palindrome_finder lpf_checker u_lpf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// stream-level check of the longest palindrome finder
// ---------------------------------------------------------------------------
// Strings are sent one byte per word, with the final byte flagged on tlast.
// A software Manacher scan tracks every accepted byte and queues the start,
// length and interleaved center that each finished string must produce.
// The strings cover short directed corner cases, random strings that are
// rich in palindromes, and buffer-full strings, some with tail bytes dropped.
// Both sides insert random wait states between words.
// ---------------------------------------------------------------------------
module testbench;

   localparam int TEXT_DEPTH = lpf_pkg::MAX_LEN;
   localparam int RAD_SLOTS  = lpf_pkg::RAD_DEPTH;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } char_word_type;

   typedef struct packed {
      logic [lpf_pkg::CENTER_W-1:0] center_index;
      logic [lpf_pkg::LEN_W-1:0]    pal_length;
      logic [lpf_pkg::START_W-1:0]  start_pos;
   } palindrome_type;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [lpf_pkg::REQ_DATA_W-1:0] req_tdata;   // char_code
   logic                           req_tlast;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [lpf_pkg::RSP_DATA_W-1:0] rsp_tdata;   // start_pos, pal_length, center_index

   char_word_type  char_q[$];
   palindrome_type longest_q[$];
   logic [7:0]     draft[$];

   logic [7:0]  text_copy [TEXT_DEPTH];
   int          span_len [RAD_SLOTS];
   int          chars_held;
   int          fault_count;

   logic        req_fire;
   logic        rsp_fire;
   int          req_gap;
   int          rsp_gap;
   int          req_calm;
   int          rsp_calm;

   longest_palindrome_finder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void log_fault(string msg);
      fault_count++;
      if (fault_count <= 10) begin
         $display("%s", msg);
      end
   endfunction

   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         calm = $urandom_range(10, 60);
      end
      return $urandom_range(0, 15);
   endfunction

   // manacher scan over the interleaved positions of the held bytes
   function automatic void find_longest(int n);
      int total;
      int p;
      int r;
      int mirror;
      int room;
      int center;
      int border;
      palindrome_type res;
      total = 2 * n + 1;
      span_len[0] = 0;
      span_len[1] = 1;
      center = 1;
      border = 2;
      p = 2;
      while (p < total) begin
         r = p & 1;
         if (border > p) begin
            mirror = span_len[2 * center - p];
            room = border - p;
            r = (mirror < room) ? mirror : room;
         end
         if (border < p || p + r == border) begin
            while (p >= r + 2 && p + r + 2 <= 2 * n &&
                   text_copy[(p - r - 2) / 2] == text_copy[(p + r) / 2]) begin
               r += 2;
            end
         end
         span_len[p] = r;
         if (r > span_len[center]) begin
            center = p;
            border = p + r;
         end
         if (border + 1 >= total) begin
            break;
         end
         p++;
      end
      res.start_pos    = 8'((center - span_len[center]) / 2);
      res.pal_length   = 9'(span_len[center]);
      res.center_index = 9'(center);
      longest_q.push_back(res);
   endfunction

   function automatic void absorb_char(logic [7:0] code, logic last);
      if (chars_held < TEXT_DEPTH) begin
         text_copy[chars_held] = code;
         chars_held++;
      end
      if (last) begin
         find_longest(chars_held);
         chars_held = 0;
      end
   endfunction

   function automatic void commit_draft();
      char_word_type w;
      for (int i = 0; i < draft.size(); i++) begin
         w.code = draft[i];
         w.last = (i == draft.size() - 1);
         char_q.push_back(w);
      end
      draft.delete();
   endfunction

   function automatic logic [7:0] pick(logic [7:0] base, int span);
      return base + 8'($urandom_range(0, span - 1));
   endfunction

   // random filler, mirrored core, random filler
   function automatic void draft_palindrome(logic [7:0] base, int span);
      logic [7:0] half [16];
      int h;
      int i;
      for (i = 0; i < $urandom_range(0, 4); i++) begin
         draft.push_back(pick(base, span));
      end
      h = $urandom_range(0, 12);
      for (i = 0; i < h; i++) begin
         half[i] = pick(base, span);
         draft.push_back(half[i]);
      end
      if ($urandom_range(0, 1)) begin
         draft.push_back(pick(base, span));
      end
      for (i = h - 1; i >= 0; i--) begin
         draft.push_back(half[i]);
      end
      for (i = 0; i < $urandom_range(0, 4); i++) begin
         draft.push_back(pick(base, span));
      end
      if (draft.size() == 0) begin
         draft.push_back(pick(base, span));
      end
   endfunction

   function automatic void draft_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         draft.push_back(s[i]);
      end
   endfunction

   function automatic void build_stimulus();
      int sent;
      int kind;
      int span;
      logic [7:0] base;
      // directed corners
      draft.push_back(8'h00);
      commit_draft();
      draft.push_back(8'hff);
      commit_draft();
      draft_text("aa");
      commit_draft();
      draft_text("ab");
      commit_draft();
      draft_text("abcd");
      commit_draft();
      draft_text("abba");
      commit_draft();
      draft_text("xabay");
      commit_draft();
      draft.push_back(8'hff);
      draft.push_back(8'h00);
      draft.push_back(8'hff);
      commit_draft();
      // full buffer, one run of a single byte
      for (int i = 0; i < TEXT_DEPTH; i++) begin
         draft.push_back(8'h5a);
      end
      commit_draft();
      // overflow, the flagged byte is dropped
      for (int i = 0; i < TEXT_DEPTH + 3; i++) begin
         draft.push_back(pick(8'h30, 2));
      end
      commit_draft();
      // full buffer ending in a long mirrored tail
      for (int i = 0; i < TEXT_DEPTH / 2; i++) begin
         draft.push_back(pick(8'h61, 3));
      end
      for (int i = TEXT_DEPTH / 2 - 1; i >= 0; i--) begin
         draft.push_back(draft[i]);
      end
      draft.push_back(8'h7e);
      commit_draft();
      sent = char_q.size();
      while (sent < 1600) begin
         kind = $urandom_range(0, 9);
         span = (kind < 3) ? 2 : (kind < 6) ? 3 : (kind < 8) ? 5 : 256;
         base = 8'($urandom_range(0, 255));
         if (kind < 7) begin
            draft_palindrome(base, span);
         end else begin
            for (int i = 0; i < $urandom_range(1, 16); i++) begin
               draft.push_back(pick(base, span));
            end
         end
         sent += draft.size();
         commit_draft();
      end
   endfunction

   always @(posedge clock) begin
      palindrome_type got;
      palindrome_type want;
      req_fire <= !reset && req_tvalid && req_tready;
      rsp_fire <= !reset && rsp_tvalid && rsp_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            absorb_char(req_tdata[7:0], req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.start_pos    = rsp_tdata[7:0];
            got.pal_length   = rsp_tdata[16:8];
            got.center_index = rsp_tdata[25:17];
            if (longest_q.size() == 0) begin
               log_fault($sformatf("unexpected word: start %0d length %0d center %0d",
                  got.start_pos, got.pal_length, got.center_index));
            end else begin
               want = longest_q.pop_front();
               if (got.start_pos !== want.start_pos ||
                   got.pal_length !== want.pal_length ||
                   got.center_index !== want.center_index) begin
                  log_fault($sformatf(
                     "mismatch: start %0d/%0d length %0d/%0d center %0d/%0d (exp/got)",
                     want.start_pos, got.start_pos, want.pal_length, got.pal_length,
                     want.center_index, got.center_index));
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_fire) begin
            void'(char_q.pop_front());
            req_gap = draw_gap(req_calm);
         end
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (char_q.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= char_q[0].code;
            req_tlast  <= char_q[0].last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_fire) begin
            rsp_gap = draw_gap(rsp_calm);
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      #20000000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      rsp_tready  = 1'b0;
      req_fire    = 1'b0;
      rsp_fire    = 1'b0;
      req_gap     = 0;
      rsp_gap     = 0;
      req_calm    = 0;
      rsp_calm    = 0;
      chars_held  = 0;
      fault_count = 0;
      build_stimulus();
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      while (char_q.size() != 0 || longest_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (100) @(posedge clock);
      if (fault_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
